FILE: design/bnem_pkg.sv
// Shared types and constants for the block noise error estimator.
`timescale 1ns / 1ps
`default_nettype none
package bnem_pkg;
   localparam int unsigned DvdW = 48;
   localparam int unsigned DivW = 32;
   localparam int unsigned StepW = 6;

   typedef struct packed {
      logic              start;
      logic [DivW-1:0]   rem;
      logic [DvdW-1:0]   dvd;
      logic [DivW-1:0]   divisor;
      logic [StepW-1:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic              start;
      logic [63:0]       radicand;
   } root_req_type;
endpackage
`default_nettype wire

FILE: design/bnem_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bnem_div import bnem_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_req_type       req,
   output logic                   done,
   output logic [DvdW-1:0]        quot
);
   logic [DivW-1:0]  rem_ff, rem_in;
   logic [DvdW-1:0]  dvd_ff, dvd_in;
   logic [StepW-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DivW:0]    trial;
   logic [DivW:0]    diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, dvd_ff[DvdW-1]};
      ge = trial >= {1'b0, req.divisor};
      diff = trial - {1'b0, req.divisor};
      rem_in = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      dvd_in = {dvd_ff[DvdW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff <= req.rem;
            dvd_ff <= req.dvd;
            cnt_ff <= req.steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == StepW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = dvd_ff;
endmodule
`default_nettype wire

FILE: design/bnem_root.sv
// Serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bnem_root import bnem_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire root_req_type  req,
   output logic               done,
   output logic [31:0]        root
);
   logic [63:0] v_ff;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [34:0] remn, trial;
   logic        ge;

   always_comb begin
      remn = {rem_ff[32:0], v_ff[63:62]};
      trial = {1'b0, root_ff, 2'b01};
      ge = remn >= trial;
      rem_in = ge ? remn - trial : remn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            v_ff <= req.radicand;
            rem_ff <= '0;
            root_ff <= '0;
            cnt_ff <= 6'd32;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            v_ff <= {v_ff[61:0], 2'b00};
            rem_ff <= rem_in;
            root_ff <= {root_ff[30:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

FILE: design/block_noise_error_max.sv
// Each pixel runs six normalizing divisions, then the sums, the square root and the final
// division, and then the output. Zero weights and a zero sum shorten the work.
// One pixel is in work at a time; ready is low while a pixel is in work.
// The result word is registered and appears after the last pixel.
// Reset: synchronous, clears the sequencer, the running maximum and rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module block_noise_error_max import bnem_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_main_weight,
   input  wire logic signed [31:0] req_main_red,
   input  wire logic signed [31:0] req_main_green,
   input  wire logic signed [31:0] req_main_blue,
   input  wire logic [31:0]        req_half_weight,
   input  wire logic signed [31:0] req_half_red,
   input  wire logic signed [31:0] req_half_green,
   input  wire logic signed [31:0] req_half_blue,
   input  wire logic               req_is_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_block_error
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_NWAIT, ST_SUMS, ST_ROOT, ST_RWAIT, ST_DIV, ST_DWAIT, ST_DONE
   } state_type;

   state_type    state_ff;
   logic [31:0]  wm_ff, wh_ff;
   logic [31:0]  col_ff [6];
   logic         last_ff;
   logic [2:0]   idx_ff;
   logic [47:0]  mag_ff [6];
   logic         neg_ff [6];
   logic [49:0]  s_ff;
   logic [51:0]  d_ff;
   logic [31:0]  err_ff, max_ff, out_ff;
   logic         out_valid_ff;

   div_req_type  div_req;
   root_req_type root_req;
   logic         div_done, root_done;
   logic [47:0]  quot;
   logic [31:0]  root;

   logic [31:0]  cur_col, cur_w, cur_mag;
   logic [49:0]  sgn [6];
   logic [49:0]  diff [3];
   logic [49:0]  adiff [3];
   logic [49:0]  s_in;
   logic [51:0]  d_in;
   logic [31:0]  max_in;
   logic         out_load, out_valid_in;

   always_comb begin
      cur_col = col_ff[idx_ff];
      cur_w = (idx_ff < 3'd3) ? wm_ff : wh_ff;
      cur_mag = cur_col[31] ? 32'(-cur_col) : cur_col;
      for (int i = 0; i < 6; i++) begin
         sgn[i] = neg_ff[i] ? 50'(-{2'b00, mag_ff[i]}) : {2'b00, mag_ff[i]};
      end
      for (int i = 0; i < 3; i++) begin
         diff[i] = sgn[i] - sgn[i+3];
         adiff[i] = diff[i][49] ? 50'(-diff[i]) : diff[i];
      end
      s_in = 50'(mag_ff[0]) + 50'(mag_ff[1]) + 50'(mag_ff[2]);
      d_in = 52'(adiff[0]) + 52'(adiff[1]) + 52'(adiff[2]);
      max_in = (err_ff > max_ff) ? err_ff : max_ff;
      out_load = (state_ff == ST_DONE) && last_ff && (!out_valid_ff || rsp_ready);
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);

      div_req = '0;
      div_req.divisor = (state_ff == ST_DIV || state_ff == ST_DWAIT) ? root : cur_w;
      if (state_ff == ST_NORM && cur_w != '0) begin
         div_req.start = 1'b1;
         div_req.rem = '0;
         div_req.dvd = {cur_mag, 16'b0};
         div_req.steps = StepW'(48);
      end else if (state_ff == ST_DIV) begin
         div_req.start = 1'b1;
         div_req.rem = d_ff[48:17];
         div_req.dvd = {d_ff[16:0], 31'b0};
         div_req.steps = StepW'(32);
      end
      root_req.start = (state_ff == ST_ROOT);
      root_req.radicand = {s_ff, 14'b0};
   end

   bnem_div u_div (
      .clock (clock), .reset (reset), .req (div_req), .done (div_done), .quot (quot)
   );

   bnem_root u_root (
      .clock (clock), .reset (reset), .req (root_req), .done (root_done), .root (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff <= '0;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  wm_ff <= req_main_weight;
                  wh_ff <= req_half_weight;
                  col_ff[0] <= req_main_red;
                  col_ff[1] <= req_main_green;
                  col_ff[2] <= req_main_blue;
                  col_ff[3] <= req_half_red;
                  col_ff[4] <= req_half_green;
                  col_ff[5] <= req_half_blue;
                  last_ff <= req_is_last;
                  idx_ff <= '0;
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               neg_ff[idx_ff] <= cur_col[31];
               if (cur_w == '0) begin
                  mag_ff[idx_ff] <= '0;
                  if (idx_ff == 3'd5) state_ff <= ST_SUMS;
                  else idx_ff <= idx_ff + 1'b1;
               end else begin
                  state_ff <= ST_NWAIT;
               end
            end
            ST_NWAIT: begin
               if (div_done) begin
                  mag_ff[idx_ff] <= quot;
                  if (idx_ff == 3'd5) begin
                     state_ff <= ST_SUMS;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_NORM;
                  end
               end
            end
            ST_SUMS: begin
               s_ff <= s_in;
               d_ff <= d_in;
               if (s_in == '0) begin
                  err_ff <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: state_ff <= ST_RWAIT;
            ST_RWAIT: begin
               if (root_done) begin
                  if (d_ff >= {3'b000, root, 17'b0}) begin
                     err_ff <= '1;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: state_ff <= ST_DWAIT;
            ST_DWAIT: begin
               if (div_done) begin
                  err_ff <= quot[31:0];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!last_ff) begin
                  max_ff <= max_in;
                  state_ff <= ST_IDLE;
               end else if (out_load) begin
                  out_ff <= max_in;
                  max_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_block_error = out_ff;
endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for block_noise_error_max: directed table plus random blocks against a predictor.
`timescale 1ns / 1ps
module tb;
   localparam int unsigned NumRandom = 1250;
   localparam int unsigned IdleLimit = 20000;
   localparam logic [31:0] ErrSat = 32'hFFFF_FFFF;
   localparam logic [31:0] NoCheck = 32'h0;

   typedef struct {
      logic [31:0] mw;
      logic [31:0] mr, mg, mb;
      logic [31:0] hw;
      logic [31:0] hr, hg, hb;
      logic        last;
      logic        known;
      logic [31:0] err;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_main_weight = '0;
   logic signed [31:0] req_main_red = '0, req_main_green = '0, req_main_blue = '0;
   logic [31:0] req_half_weight = '0;
   logic signed [31:0] req_half_red = '0, req_half_green = '0, req_half_blue = '0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_block_error;

   logic [31:0] err_queue[$];
   logic [31:0] block_max = '0;
   int mismatches = 0;
   int idle_cycles = 0;
   bit sending_done = 1'b0;
   bit hold_off = 1'b0;
   bit no_idle = 1'b0;

   block_noise_error_max u_top (
      .clock, .reset, .req_valid, .req_ready,
      .req_main_weight, .req_main_red, .req_main_green, .req_main_blue,
      .req_half_weight, .req_half_red, .req_half_green, .req_half_blue,
      .req_is_last, .rsp_valid, .rsp_ready, .rsp_block_error
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic signed [63:0] norm_color(logic [31:0] c, logic [31:0] w);
      logic signed [63:0] s;
      logic [63:0] m;
      logic [63:0] q;
      s = 64'(signed'(c));
      if (w == 0) return 0;
      m = s < 0 ? 64'(-s) : 64'(s);
      q = (m << 16) / {32'h0, w};
      return s < 0 ? -64'(signed'(q)) : 64'(signed'(q));
   endfunction

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] pixel_noise(pixel_type p);
      logic signed [63:0] mr, mg, mb, hr, hg, hb;
      logic [63:0] s, d, r;
      mr = norm_color(p.mr, p.mw);
      mg = norm_color(p.mg, p.mw);
      mb = norm_color(p.mb, p.mw);
      hr = norm_color(p.hr, p.hw);
      hg = norm_color(p.hg, p.hw);
      hb = norm_color(p.hb, p.hw);
      s = abs64(mr) + abs64(mg) + abs64(mb);
      if (s == 0) return 0;
      d = abs64(mr - hr) + abs64(mg - hg) + abs64(mb - hb);
      r = int_sqrt(s << 14);
      if (d >= (r << 17)) return ErrSat;
      return 32'((d << 15) / r);
   endfunction

   function automatic pixel_type make_pixel(logic [31:0] mw, logic [31:0] mr, logic [31:0] mg,
                                            logic [31:0] mb, logic [31:0] hw, logic [31:0] hr,
                                            logic [31:0] hg, logic [31:0] hb, logic last,
                                            logic known, logic [31:0] err);
      pixel_type p;
      p.mw = mw; p.mr = mr; p.mg = mg; p.mb = mb;
      p.hw = hw; p.hr = hr; p.hg = hg; p.hb = hb;
      p.last = last; p.known = known; p.err = err;
      return p;
   endfunction

   function automatic logic [31:0] rand_color(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'(signed'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
         2: return 32'($urandom_range(0, 32'h00FF_FFFF));
         default: return {32{$urandom_range(0, 1) == 1}} ^ 32'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(1, 16);
         default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
      endcase
   endfunction

   function automatic pixel_type rand_pixel(logic last);
      pixel_type p;
      int mode;
      logic [31:0] main_r, main_g, main_b;
      mode = $urandom_range(0, 3);
      main_r = rand_color(mode);
      main_g = rand_color(mode);
      main_b = rand_color(mode);
      p.mw = rand_weight();
      p.hw = $urandom_range(0, 3) == 0 ? p.mw : rand_weight();
      p.mr = main_r; p.mg = main_g; p.mb = main_b;
      if ($urandom_range(0, 2) == 0) begin
         p.hr = main_r ^ 32'($urandom_range(0, 4095));
         p.hg = main_g ^ 32'($urandom_range(0, 4095));
         p.hb = main_b ^ 32'($urandom_range(0, 4095));
      end else begin
         p.hr = rand_color(mode);
         p.hg = rand_color(mode);
         p.hb = rand_color(mode);
      end
      p.last = last;
      p.known = 1'b0;
      p.err = NoCheck;
      return p;
   endfunction

   task automatic send_pixel(pixel_type p);
      logic [31:0] e;
      while (!no_idle && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_main_weight <= p.mw;
      req_main_red <= p.mr;
      req_main_green <= p.mg;
      req_main_blue <= p.mb;
      req_half_weight <= p.hw;
      req_half_red <= p.hr;
      req_half_green <= p.hg;
      req_half_blue <= p.hb;
      req_is_last <= p.last;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      e = pixel_noise(p);
      if (e > block_max) block_max = e;
      if (p.last) begin
         err_queue.insert(err_queue.size(), p.known ? p.err : block_max);
         if (p.known && p.err != block_max) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row error %h disagrees with predictor %h", p.err, block_max);
         end
         block_max = '0;
      end
      @(negedge clock);
   endtask

   task automatic run_directed();
      pixel_type rows[$];
      rows.insert(rows.size(),
                  make_pixel(0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 5, 6, 7, 1, 1, 0));
      rows.insert(rows.size(),
                  make_pixel(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 0));
      rows.insert(rows.size(),
                  make_pixel(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000,
                             32'h0001_0000, 0, 0, 1, 1, 0));
      rows.insert(rows.size(),
                  make_pixel(1, 32'h0000_0001, 0, 0, 0, 0, 0, 0, 1, 1, 32'h0001_0000));
      rows.insert(rows.size(),
                  make_pixel(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 1, 0, NoCheck));
      rows.insert(rows.size(),
                  make_pixel(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, NoCheck));
      rows.insert(rows.size(),
                  make_pixel(32'h0001_0000, 32'h0004_0000, 32'h0002_0000, 32'hFFFF_0000,
                             32'h0002_0000, 32'h0004_0000, 0, 32'hFFFE_0000, 0, 0, NoCheck));
      rows.insert(rows.size(),
                  make_pixel(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                             0, 0, 0, 0, 0, 0, NoCheck));
      rows.insert(rows.size(),
                  make_pixel(32'h0001_0000, 32'h0010_0000, 0, 0, 32'h0001_0000,
                             32'h0010_1000, 0, 0, 1, 0, NoCheck));
      rows.insert(rows.size(),
                  make_pixel(32'h0003_0000, 32'hFFF0_0000, 32'h0000_0001, 32'h1234_5678,
                             32'h0001_8000, 32'hFFF8_0000, 32'h0000_0002, 32'h0912_3456,
                             0, 0, NoCheck));
      rows.insert(rows.size(),
                  make_pixel(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 1, 0, NoCheck));
      foreach (rows[i]) send_pixel(rows[i]);
   endtask

   initial begin
      int sent;
      int len;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      sent = 0;
      while (sent < NumRandom) begin
         len = $urandom_range(0, 5) == 0 ? $urandom_range(1, 20) : $urandom_range(1, 4);
         no_idle = sent >= 400 && sent < 550;
         for (int k = 0; k < len; k++) send_pixel(rand_pixel(k == len - 1));
         sent += len;
         if (sent >= 700 && sent < 720) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (err_queue.size() != 0);
         end
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= $urandom_range(0, 99) >= 37;
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (err_queue.size() >= 1);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (err_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_block_error);
         end else begin
            logic [31:0] want;
            want = err_queue[0];
            err_queue.delete(0);
            if (rsp_block_error !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("block_error expected %h actual %h", want, rsp_block_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      wait (sending_done);
      while (err_queue.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/bnem_pkg.sv
design/bnem_div.sv
design/bnem_root.sv
design/block_noise_error_max.sv
test/tb.sv
